FILE: sv/ptq_pkg.sv
package ptq_pkg;

  localparam int QUEUE_DEPTH     = 256;
  localparam int PRIORITY_LEVELS = 4;

  localparam int NUM_QUEUES = 2 * PRIORITY_LEVELS;
  localparam int QW         = $clog2(QUEUE_DEPTH);
  localparam int CW         = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W     = $clog2(NUM_QUEUES);
  localparam int ADDR_W     = QIDX_W + QW;
  localparam int MEM_DEPTH  = 2 ** ADDR_W;

  localparam logic [2:0] KIND_PUSH     = 3'd0;
  localparam logic [2:0] KIND_POP_PERF = 3'd1;
  localparam logic [2:0] KIND_POP_EFF  = 3'd2;
  localparam logic [2:0] KIND_POP_HELP = 3'd3;
  localparam logic [2:0] KIND_POP_ONE  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              hit;
    logic [QIDX_W-1:0] q;
    logic              cls;
    logic [1:0]        prio;
  } ptq_sel_t;

endpackage

FILE: sv/ptq_if.sv
interface ptq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [1:0] priority_req;
  logic       core_class;
  logic [8:0] task_handle;

  modport source (output valid, kind, priority_req, core_class, task_handle, input ready);
  modport sink   (input valid, kind, priority_req, core_class, task_handle, output ready);
endinterface

interface ptq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [8:0] popped_handle;
  logic       from_class;
  logic [1:0] from_priority;

  modport source (output valid, status, popped_handle, from_class, from_priority, input ready);
  modport sink   (input valid, status, popped_handle, from_class, from_priority, output ready);
endinterface

FILE: sv/ptq_pick.sv
module ptq_pick (
  input  logic [2:0]                   kind,
  input  logic [1:0]                   prio,
  input  logic [ptq_pkg::NUM_QUEUES-1:0] nonempty,
  output ptq_pkg::ptq_sel_t            sel
);

  logic [ptq_pkg::QIDX_W-1:0] cand;
  logic [ptq_pkg::QIDX_W-1:0] qsel;
  logic                       hit;

  // first non-empty queue in the order of the pop kind; POP_ONE checks only the queue given by prio
  always_comb begin
    hit  = 1'b0;
    qsel = '0;
    cand = '0;
    for (int k = 0; k < ptq_pkg::NUM_QUEUES; k++) begin
      case (kind)
        ptq_pkg::KIND_POP_PERF: cand = ptq_pkg::QIDX_W'(k);
        ptq_pkg::KIND_POP_EFF:  cand = ptq_pkg::QIDX_W'(ptq_pkg::NUM_QUEUES - 1 - k);
        ptq_pkg::KIND_POP_HELP: cand = ptq_pkg::QIDX_W'((k & 1) * ptq_pkg::PRIORITY_LEVELS
                                                        + (k >> 1));
        default:                cand = '0;
      endcase
      if (!hit && nonempty[cand] && (kind == ptq_pkg::KIND_POP_PERF ||
          kind == ptq_pkg::KIND_POP_EFF || kind == ptq_pkg::KIND_POP_HELP)) begin
        hit  = 1'b1;
        qsel = cand;
      end
    end
    if (kind == ptq_pkg::KIND_POP_ONE) begin
      qsel = ptq_pkg::QIDX_W'(prio);
      hit  = (int'(prio) < ptq_pkg::PRIORITY_LEVELS) && nonempty[qsel];
    end
  end

  always_comb begin
    sel.hit = hit;
    sel.q   = qsel;
    if (int'(qsel) >= ptq_pkg::PRIORITY_LEVELS) begin
      sel.cls  = 1'b1;
      sel.prio = 2'(qsel - ptq_pkg::QIDX_W'(ptq_pkg::PRIORITY_LEVELS));
    end else begin
      sel.cls  = 1'b0;
      sel.prio = 2'(qsel);
    end
  end

endmodule

FILE: sv/priority_task_queue_bank_with_stealing.sv
// Bank of 2 x PRIORITY_LEVELS bounded FIFO task queues (performance and
// efficiency class per priority) sharing one handle memory with a registered
// read; head pointers and fill counts sit in flip-flops, so the queue
// search is a priority pick over the non-empty flags. Every transaction on
// in_ch gives exactly one on out_ch, in order. One item is accepted per cycle
// unless the output stalls; the result passes the memory read register, then
// the output register, and a stalled output holds at most one item in flight
// behind it. No clearing pass: the memory is only read where a push wrote.
module priority_task_queue_bank_with_stealing (
  input logic       clk,
  input logic       rst_n,
  ptq_in_if.sink    in_ch,
  ptq_out_if.source out_ch
);

  localparam int NQ = ptq_pkg::NUM_QUEUES;
  localparam int QW = ptq_pkg::QW;
  localparam int CW = ptq_pkg::CW;
  localparam int XW = ptq_pkg::QIDX_W;

  logic [8:0] mem [ptq_pkg::MEM_DEPTH];

  logic [QW-1:0] head_r [NQ];
  logic [CW-1:0] fill_r [NQ];
  logic [NQ-1:0] nonempty;

  ptq_pkg::ptq_sel_t sel;

  logic          accept;
  logic          is_push;
  logic          is_pop;
  logic          prio_ok;
  logic [XW-1:0] qp;
  logic [CW-1:0] push_fill;
  logic          push_ok;
  logic          pop_ok;
  logic [QW:0]   tail_sum;
  logic [QW-1:0] tail;
  logic [QW-1:0] pop_head;
  logic [QW-1:0] pop_head_inc;

  logic          pend_r;
  logic          pend_nxt;
  logic          move;
  logic [1:0]    p_status_r;
  logic          p_cls_r;
  logic [1:0]    p_prio_r;
  logic          p_pop_r;
  logic [8:0]    rd_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [8:0]    out_handle_r;
  logic          out_cls_r;
  logic [1:0]    out_prio_r;

  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      nonempty[q] = (fill_r[q] != '0);
    end
  end

  ptq_pick u_pick (
    .kind     (in_ch.kind),
    .prio     (in_ch.priority_req),
    .nonempty (nonempty),
    .sel      (sel)
  );

  assign move        = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_push = (in_ch.kind == ptq_pkg::KIND_PUSH);
  assign is_pop  = (in_ch.kind == ptq_pkg::KIND_POP_PERF) ||
                   (in_ch.kind == ptq_pkg::KIND_POP_EFF)  ||
                   (in_ch.kind == ptq_pkg::KIND_POP_HELP) ||
                   (in_ch.kind == ptq_pkg::KIND_POP_ONE);
  assign prio_ok = int'(in_ch.priority_req) < ptq_pkg::PRIORITY_LEVELS;
  assign qp      = in_ch.core_class ?
                   XW'(ptq_pkg::PRIORITY_LEVELS) + XW'(in_ch.priority_req) :
                   XW'(in_ch.priority_req);

  always_comb begin
    push_fill = prio_ok ? fill_r[qp] : '0;
    push_ok   = is_push && prio_ok && (push_fill != CW'(ptq_pkg::QUEUE_DEPTH));
    pop_ok    = is_pop && sel.hit;
    tail_sum  = (QW+1)'(head_r[qp]) + (QW+1)'(push_fill);
    if (tail_sum >= (QW+1)'(ptq_pkg::QUEUE_DEPTH)) begin
      tail = QW'(tail_sum - (QW+1)'(ptq_pkg::QUEUE_DEPTH));
    end else begin
      tail = QW'(tail_sum);
    end
    pop_head     = head_r[sel.q];
    pop_head_inc = (pop_head == QW'(ptq_pkg::QUEUE_DEPTH - 1)) ? '0 : pop_head + 1'b1;
  end

  // write lands at the edge, so a pop of that entry in the next cycle reads it
  always_ff @(posedge clk) begin
    if (accept && push_ok) begin
      mem[{qp, tail}] <= in_ch.task_handle;
    end
    if (accept && pop_ok) begin
      rd_r <= mem[{sel.q, pop_head}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NQ; q++) begin
        head_r[q] <= '0;
        fill_r[q] <= '0;
      end
    end else if (accept) begin
      if (push_ok) begin
        fill_r[qp] <= push_fill + 1'b1;
      end else if (pop_ok) begin
        head_r[sel.q] <= pop_head_inc;
        fill_r[sel.q] <= fill_r[sel.q] - 1'b1;
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_pop_r <= pop_ok;
      if (is_push) begin
        p_status_r <= push_ok ? ptq_pkg::ST_DONE : ptq_pkg::ST_FULL;
        p_cls_r    <= in_ch.core_class;
        p_prio_r   <= in_ch.priority_req;
      end else if (pop_ok) begin
        p_status_r <= ptq_pkg::ST_DONE;
        p_cls_r    <= sel.cls;
        p_prio_r   <= sel.prio;
      end else begin
        p_status_r <= ptq_pkg::ST_EMPTY;
        p_cls_r    <= 1'b0;
        p_prio_r   <= 2'd0;
      end
    end
    if (move) begin
      out_status_r <= p_status_r;
      out_handle_r <= p_pop_r ? rd_r : 9'd0;
      out_cls_r    <= p_cls_r;
      out_prio_r   <= p_prio_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.popped_handle = out_handle_r;
  assign out_ch.from_class    = out_cls_r;
  assign out_ch.from_priority = out_prio_r;

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid_r && !out_ch.ready |=> pend_r)
    else $error("pending result lost under output stall");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && push_ok |=> fill_r[$past(qp)] == $past(push_fill) + 1'b1)
    else $error("fill count not advanced by push");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ptq_pkg::ST_EMPTY |->
      out_handle_r == 9'd0 && !out_cls_r && out_prio_r == 2'd0)
    else $error("empty result carries nonzero fields");

  a_push_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_push |=> !p_pop_r)
    else $error("push marked as pop");

endmodule
